FILE: rtl/core/shell_command_lexer_core_assert.svh
// Assertion macros shared by the lexer RTL.
`ifndef SHELL_COMMAND_LEXER_CORE_ASSERT_SVH
`define SHELL_COMMAND_LEXER_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define SCL_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lexer assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define SCL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lexer assertion failed");

`endif

FILE: rtl/core/scl_pkg.sv
// Types, character codes and helper functions for the shell command lexer.
package scl_pkg;

  localparam int MaxEv   = 4;
  localparam int EvIdxW  = $clog2(MaxEv);
  localparam int EvCntW  = $clog2(MaxEv + 1);

  typedef enum logic [2:0] {
    MODE_NORMAL     = 3'd0,
    MODE_SINGLE     = 3'd1,
    MODE_DOUBLE     = 3'd2,
    MODE_DOUBLE_ESC = 3'd3,
    MODE_COMMENT    = 3'd4
  } lex_mode_t;

  typedef enum logic [1:0] {
    EV_WORD_BYTE = 2'd0,
    EV_OP_BYTE   = 2'd1,
    EV_WORD_END  = 2'd2,
    EV_OP_END    = 2'd3
  } ev_kind_t;

  typedef struct packed {
    logic [7:0] b;
    ev_kind_t   k;
  } ev_t;

  typedef struct packed {
    ev_t [MaxEv-1:0]   ev;
    logic [EvCntW-1:0] n;
  } ev_list_t;

  localparam logic [7:0] CH_PIPE   = 8'h7C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_BTICK  = 8'h60;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_NUL    = 8'h00;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL) ||
           (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
  endfunction

  function automatic logic is_pairable(input logic [7:0] c);
    return (c == CH_PIPE) || (c == CH_AMP) || (c == CH_LT) || (c == CH_GT);
  endfunction

  function automatic logic is_operator(input logic [7:0] c);
    return is_pairable(c) || (c == CH_SEMI) || (c == CH_LPAREN) || (c == CH_RPAREN);
  endfunction

  function automatic logic is_dq_esc(input logic [7:0] c);
    return (c == CH_BSLASH) || (c == CH_DQUOTE) || (c == CH_BTICK) || (c == CH_DOLLAR);
  endfunction

  // append one event; drop it once the list is full
  function automatic ev_list_t push(input ev_list_t l, input logic [7:0] b,
                                    input ev_kind_t k);
    ev_list_t r;
    r = l;
    if (l.n < EvCntW'(MaxEv)) begin
      r.ev[l.n[EvIdxW-1:0]].b = b;
      r.ev[l.n[EvIdxW-1:0]].k = k;
      r.n = l.n + EvCntW'(1);
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/shell_command_lexer_core.sv
// Shell command lexer: bytes in, word and operator token events out.
//
// Input channel: in_valid / in_stall carry one command-line byte (in_byte)
// and in_end_of_input, set on the final byte of a command line.
// Output channel: out_valid / out_stall carry one token event per beat:
// out_byte, out_event_kind (word byte, operator byte, word end, operator end)
// and out_last_of_run, set on the last event caused by one input byte.
// A byte is decoded in the cycle it is accepted; its events sit in a
// four-entry result buffer and the first one is shown the next cycle.
// The buffer hands out one event per cycle while out_stall is low.
// Throughput: one byte per cycle while each byte yields at most one event
// and out_stall is low. A byte that yields k events (k up to 4) holds
// in_stall while the buffer drains. in_stall is high while more than one
// buffered event is left, or one is left and out_stall is high.
// Reset (rst_n low, synchronous): buffer empty, normal mode, no open word,
// no pending operator. End of input flushes; all but the buffer return to that state.
// out_stall holds the shown event and the rest of the buffer.
`include "shell_command_lexer_core_assert.svh"

module shell_command_lexer_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_input,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic [1:0] out_event_kind,
  output logic       out_last_of_run
);
  import scl_pkg::*;

  lex_mode_t              mode_r, mode_nxt;
  logic                   word_open_r, word_open_nxt;
  logic [7:0]             held_r, held_nxt;
  logic                   held_valid_r, held_valid_nxt;
  ev_list_t               evl;
  ev_t [MaxEv-1:0]        buf_r;
  logic [EvIdxW-1:0]      hd_r;
  logic [EvCntW-1:0]      cnt_r;
  logic                   in_fire, out_fire;
  logic [7:0]             c;

  assign c         = in_byte;
  assign out_valid = (cnt_r != '0);
  assign out_fire  = out_valid && !out_stall;
  assign in_stall  = !((cnt_r == '0) || ((cnt_r == EvCntW'(1)) && !out_stall));
  assign in_fire   = in_valid && !in_stall;

  assign out_byte        = buf_r[hd_r].b;
  assign out_event_kind  = buf_r[hd_r].k;
  assign out_last_of_run = (cnt_r == EvCntW'(1));

  always_comb begin
    evl            = '0;
    mode_nxt       = mode_r;
    word_open_nxt  = word_open_r;
    held_nxt       = held_r;
    held_valid_nxt = held_valid_r;
    unique case (mode_r)
      MODE_SINGLE: begin
        if (c == CH_SQUOTE) begin
          mode_nxt = MODE_NORMAL;
        end else begin
          evl = push(evl, c, EV_WORD_BYTE);
          word_open_nxt = 1'b1;
        end
      end
      MODE_DOUBLE: begin
        priority if (c == CH_DQUOTE) begin
          mode_nxt = MODE_NORMAL;
        end else if (c == CH_BSLASH) begin
          mode_nxt = MODE_DOUBLE_ESC;
        end else begin
          evl = push(evl, c, EV_WORD_BYTE);
          word_open_nxt = 1'b1;
        end
      end
      MODE_DOUBLE_ESC: begin
        if (!is_dq_esc(c)) begin
          evl = push(evl, CH_BSLASH, EV_WORD_BYTE);
        end
        evl = push(evl, c, EV_WORD_BYTE);
        word_open_nxt = 1'b1;
        mode_nxt = MODE_DOUBLE;
      end
      MODE_COMMENT: begin
        if (c == CH_NL) begin
          mode_nxt = MODE_NORMAL;
        end
      end
      default: begin
        mode_nxt = MODE_NORMAL;
        if (is_operator(c)) begin
          if (held_valid_r && (held_r == c) && is_pairable(c)) begin
            held_valid_nxt = 1'b0;
            held_nxt = '0;
            evl = push(evl, c, EV_OP_BYTE);
            evl = push(evl, c, EV_OP_BYTE);
            evl = push(evl, CH_NUL, EV_OP_END);
          end else begin
            if (held_valid_r) begin
              evl = push(evl, held_r, EV_OP_BYTE);
              evl = push(evl, CH_NUL, EV_OP_END);
              held_valid_nxt = 1'b0;
              held_nxt = '0;
            end
            if (word_open_r) begin
              evl = push(evl, CH_NUL, EV_WORD_END);
              word_open_nxt = 1'b0;
            end
            if (is_pairable(c)) begin
              held_nxt = c;
              held_valid_nxt = 1'b1;
            end else begin
              evl = push(evl, c, EV_OP_BYTE);
              evl = push(evl, CH_NUL, EV_OP_END);
            end
          end
        end else begin
          if (held_valid_r) begin
            evl = push(evl, held_r, EV_OP_BYTE);
            evl = push(evl, CH_NUL, EV_OP_END);
            held_valid_nxt = 1'b0;
            held_nxt = '0;
          end
          priority if (is_space(c)) begin
            if (word_open_r) begin
              evl = push(evl, CH_NUL, EV_WORD_END);
              word_open_nxt = 1'b0;
            end
          end else if (c == CH_SQUOTE) begin
            mode_nxt = MODE_SINGLE;
          end else if (c == CH_DQUOTE) begin
            mode_nxt = MODE_DOUBLE;
          end else if ((c == CH_HASH) && !word_open_r) begin
            mode_nxt = MODE_COMMENT;
          end else begin
            evl = push(evl, c, EV_WORD_BYTE);
            word_open_nxt = 1'b1;
          end
        end
      end
    endcase

    // flush at end of input
    if (in_end_of_input) begin
      if (mode_nxt == MODE_DOUBLE_ESC) begin
        evl = push(evl, CH_BSLASH, EV_WORD_BYTE);
        word_open_nxt = 1'b1;
      end
      if (held_valid_nxt) begin
        evl = push(evl, held_nxt, EV_OP_BYTE);
        evl = push(evl, CH_NUL, EV_OP_END);
      end
      if (word_open_nxt) begin
        evl = push(evl, CH_NUL, EV_WORD_END);
      end
      mode_nxt       = MODE_NORMAL;
      word_open_nxt  = 1'b0;
      held_nxt       = '0;
      held_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_NORMAL;
      word_open_r  <= 1'b0;
      held_r       <= '0;
      held_valid_r <= 1'b0;
      hd_r         <= '0;
      cnt_r        <= '0;
    end else begin
      if (in_fire) begin
        mode_r       <= mode_nxt;
        word_open_r  <= word_open_nxt;
        held_r       <= held_nxt;
        held_valid_r <= held_valid_nxt;
      end
      if (in_fire && (evl.n != '0)) begin
        hd_r  <= '0;
        cnt_r <= evl.n;
      end else if (out_fire) begin
        hd_r  <= hd_r + EvIdxW'(1);
        cnt_r <= cnt_r - EvCntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && (evl.n != '0)) begin
      buf_r <= evl.ev;
    end
  end

  `SCL_ASSERT_SAME(a_accept_when_drained, in_fire, (cnt_r == '0) || out_fire)
  `SCL_ASSERT_SAME(a_held_excludes_word, held_valid_r, !word_open_r)
  `SCL_ASSERT_SAME(a_held_pairable, held_valid_r, is_pairable(held_r))
  `SCL_ASSERT_NEXT(a_eoi_resets, in_fire && in_end_of_input, (mode_r == MODE_NORMAL) && !word_open_r && !held_valid_r)

endmodule
